@@ rtl/irtx_pkg.sv @@
// Shared types and constants for the IR pulse-train transmitter.
// Used by the channel interfaces and the top level.
package irtx_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Command codes of an input item
  localparam logic [CMD_W-1:0] CMD_IDLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_TOP = 1'd1;

  localparam logic [CNT_W-1:0] TICK_PERIOD_RST = 16'd255;
  localparam logic [CNT_W-1:0] CARRIER_TOP_RST = 16'd210;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ENTRY_W-1:0] entry_index;
    logic [TICKS_W-1:0] pulse_ticks;
    logic [IDX_W-1:0]   code_length;
  } in_item_t;

  typedef struct packed {
    logic ir_out;
    logic carrier_on;
    logic sending;
  } out_item_t;

endpackage

@@ rtl/irtx_if.sv @@
// Valid/ready channel interfaces of the IR pulse-train transmitter.
// Depends on irtx_pkg for the payload types.
interface irtx_in_if;
  import irtx_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface irtx_out_if;
  import irtx_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface irtx_cfg_if;
  import irtx_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/irtx_pulse_mem.sv @@
// Pulse length table: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
module irtx_pulse_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/ir_pulse_train_transmitter.sv @@
// IR pulse-train transmitter. Every accepted input item is one timer step and yields exactly one
// result item (ir_out, carrier_on, sending) holding the state after that step; a new item is
// taken every clock cycle while the output register is free or being drained, so the block
// sustains one item per cycle; the result is registered. Pulse lengths live in a
// synchronous table that is read every cycle at the index the next step will use, so the length
// of the current pulse is always waiting in the read register; a table write that hits the
// current or the next index is forwarded. Configuration is taken at once on the cfg channel.
// Depends on irtx_pkg, the channel interfaces and irtx_pulse_mem.
module ir_pulse_train_transmitter #(
  parameter int unsigned PULSE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  irtx_cfg_if.sink   cfg_i,
  irtx_in_if.sink    in_i,
  irtx_out_if.source out_o
);
  import irtx_pkg::*;

  localparam int unsigned AW = (PULSE_DEPTH > 1) ? $clog2(PULSE_DEPTH) : 1;
  localparam int unsigned XW = AW + IDX_W;

  logic [CNT_W-1:0] tick_period_q, carrier_top_q;

  logic [IDX_W-1:0] pulse_index_q, pulse_index_d;
  logic [IDX_W-1:0] active_len_q, active_len_d;
  logic [CNT_W-1:0] tick_count_q, tick_count_d;
  logic [CNT_W-1:0] prescale_q, prescale_d;
  logic [CNT_W-1:0] carrier_cnt_q, carrier_cnt_d;
  logic             carrier_lvl_q, carrier_lvl_d;
  logic             carrier_en_q, carrier_en_d;

  logic      out_valid_q;
  out_item_t out_data_q;

  logic             accept;
  logic             in_ready;
  in_item_t         item;
  logic             wr_en;
  logic [XW-1:0]    wr_idx_x, cur_idx_x, rd_idx_x;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [TICKS_W-1:0] rd_data;
  logic [TICKS_W-1:0] cur_len;
  logic             cur_in_range;
  logic             tick;
  logic             restart;
  logic [CNT_W-1:0] tick_inc;
  logic [IDX_W-1:0] index_inc;

  assign item     = in_i.data;
  assign in_ready = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept   = in_i.valid && in_ready;

  // Table addressing: indexes past the table never write and read as zero length
  assign wr_idx_x  = XW'(item.entry_index);
  assign wr_addr   = wr_idx_x[AW-1:0];
  assign wr_en     = accept && (item.command == CMD_WRITE) && (wr_idx_x < XW'(PULSE_DEPTH));

  assign cur_idx_x    = XW'(pulse_index_q);
  assign cur_in_range = cur_idx_x < XW'(PULSE_DEPTH);

  assign rd_idx_x = XW'(pulse_index_d);
  assign rd_addr  = rd_idx_x[AW-1:0];

  irtx_pulse_mem #(
    .DEPTH (PULSE_DEPTH),
    .AW    (AW),
    .DW    (TICKS_W)
  ) u_pulse_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (item.pulse_ticks),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Length of the current pulse, seeing a write made in this same step
  always_comb begin
    if (!cur_in_range) begin
      cur_len = '0;
    end else if (wr_en && (wr_idx_x == cur_idx_x)) begin
      cur_len = item.pulse_ticks;
    end else begin
      cur_len = rd_data;
    end
  end

  assign tick      = prescale_q >= tick_period_q;
  assign tick_inc  = tick_count_q + CNT_W'(1);
  assign index_inc = pulse_index_q + IDX_W'(1);

  always_comb begin
    pulse_index_d = pulse_index_q;
    active_len_d  = active_len_q;
    tick_count_d  = tick_count_q;
    prescale_d    = prescale_q;
    carrier_cnt_d = carrier_cnt_q;
    carrier_lvl_d = carrier_lvl_q;
    carrier_en_d  = carrier_en_q;
    restart       = 1'b0;
    if (accept) begin
      if (item.command == CMD_START) begin
        active_len_d  = (item.code_length - IDX_W'(1)) | IDX_W'(1);
        pulse_index_d = '0;
        tick_count_d  = '0;
        prescale_d    = '0;
        carrier_en_d  = 1'b1;
        carrier_cnt_d = '0;
        carrier_lvl_d = 1'b0;
      end else begin
        if (tick) begin
          prescale_d = '0;
          if (pulse_index_q < active_len_q) begin
            if (tick_inc >= cur_len) begin
              // Advance to the next pulse: odd is a space, even a mark
              pulse_index_d = index_inc;
              tick_count_d  = '0;
              if (index_inc[0]) begin
                carrier_en_d = 1'b0;
              end else begin
                carrier_en_d  = 1'b1;
                carrier_cnt_d = '0;
                carrier_lvl_d = 1'b0;
                restart       = 1'b1;
              end
            end else begin
              tick_count_d = tick_inc;
            end
          end
        end else begin
          prescale_d = prescale_q + CNT_W'(1);
        end
        if (!restart) begin
          if (carrier_cnt_q >= carrier_top_q) begin
            carrier_cnt_d = '0;
            carrier_lvl_d = !carrier_lvl_q;
          end else begin
            carrier_cnt_d = carrier_cnt_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_index_q <= '0;
      active_len_q  <= '0;
      tick_count_q  <= '0;
      prescale_q    <= '0;
      carrier_cnt_q <= '0;
      carrier_lvl_q <= 1'b0;
      carrier_en_q  <= 1'b0;
    end else begin
      pulse_index_q <= pulse_index_d;
      active_len_q  <= active_len_d;
      tick_count_q  <= tick_count_d;
      prescale_q    <= prescale_d;
      carrier_cnt_q <= carrier_cnt_d;
      carrier_lvl_q <= carrier_lvl_d;
      carrier_en_q  <= carrier_en_d;
    end
  end

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      carrier_top_q <= CARRIER_TOP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TICK_PERIOD: tick_period_q <= cfg_i.data;
        REG_CARRIER_TOP: carrier_top_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.ir_out     <= carrier_lvl_d & carrier_en_d;
      out_data_q.carrier_on <= carrier_en_d;
      out_data_q.sending    <= pulse_index_d < active_len_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
